// ===== sv/cpa_pkg.sv =====
// shared types, constants and codes of the core pool allocator
package cpa_pkg;

   localparam int NUM_CORES = 16;
   localparam int MAX_SLOTS = 16;
   localparam int CORE_W    = 4;
   localparam int CNT_W     = 5;
   localparam int TIME_W    = 32;
   localparam int USAGE_W   = 40;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;

   localparam logic [USAGE_W-1:0] USAGE_MAX = '1;
   localparam logic [CNT_W-1:0] CORES_IN_USE_RST = CNT_W'(NUM_CORES);

   localparam logic [1:0] MODE_ALLOC   = 2'd0;
   localparam logic [1:0] MODE_RELEASE = 2'd1;
   localparam logic [1:0] MODE_READ    = 2'd2;

   // word select bit of the csr address
   localparam logic CSR_WORD_CORES_IN_USE = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_ALLOC,
      ST_MEM_RD,
      ST_CALC,
      ST_ACCUM,
      ST_SINGLE
   } state_type;

   typedef struct packed {
      logic load;
      logic alloc_step;
      logic mem_rd;
      logic calc;
      logic accum_step;
      logic single_step;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       idx_ok;
      logic       last_slot;
      logic       out_free;
   } sts_type;

endpackage

// ===== sv/cpa_ctrl.sv =====
// controller state machine of the core pool allocator
module cpa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cpa_pkg::sts_type sts,
   output cpa_pkg::cmd_type cmd
);
   import cpa_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            unique case (sts.mode) inside
               MODE_ALLOC: state_in = ST_ALLOC;
               MODE_RELEASE, MODE_READ: begin
                  state_in = sts.idx_ok ? ST_MEM_RD : ST_SINGLE;
               end
               default: state_in = ST_SINGLE;
            endcase
         end
         ST_ALLOC: begin
            if (sts.out_free && sts.last_slot) state_in = ST_IDLE;
         end
         ST_MEM_RD: state_in = ST_CALC;
         ST_CALC:   state_in = ST_ACCUM;
         ST_ACCUM: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         ST_SINGLE: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_ALLOC:  cmd.alloc_step  = sts.out_free;
         ST_MEM_RD: cmd.mem_rd      = 1'b1;
         ST_CALC:   cmd.calc        = 1'b1;
         ST_ACCUM:  cmd.accum_step  = sts.out_free;
         ST_SINGLE: cmd.single_step = sts.out_free;
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ===== sv/cpa_datapath.sv =====
// datapath of the core pool allocator: core state, time stores, usage math, result register
module cpa_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  cpa_pkg::cmd_type              cmd,
   output cpa_pkg::sts_type              sts,
   input  logic [1:0]                    req_mode,
   input  logic [cpa_pkg::CNT_W-1:0]     req_count,
   input  logic [cpa_pkg::CORE_W-1:0]    req_core_index,
   input  logic [cpa_pkg::TIME_W-1:0]    req_now,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_granted,
   output logic [cpa_pkg::CORE_W-1:0]    rsp_granted_core,
   output logic [cpa_pkg::USAGE_W-1:0]   rsp_usage,
   output logic                          rsp_last,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [cpa_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [cpa_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [cpa_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);
   import cpa_pkg::*;

   // configuration
   logic [CNT_W-1:0] cores_in_use_ff;
   logic             csr_wr;

   // transaction fields
   logic [1:0]        mode_ff;
   logic [CORE_W-1:0] idx_ff;
   logic [TIME_W-1:0] now_ff;
   logic              zero_ff;
   logic [CNT_W-1:0]  slots_ff;
   logic [CNT_W-1:0]  slots_in;

   // core state
   logic [NUM_CORES-1:0] free_ff;
   logic [NUM_CORES-1:0] free_in;
   logic [NUM_CORES-1:0] st_vld_ff;
   logic [NUM_CORES-1:0] st_vld_in;
   logic [NUM_CORES-1:0] bt_vld_ff;
   logic [NUM_CORES-1:0] bt_vld_in;
   logic [TIME_W-1:0]    start_time_ff [NUM_CORES];
   logic [USAGE_W-1:0]   busy_total_ff [NUM_CORES];
   logic [TIME_W-1:0]    st_rd_ff;
   logic [USAGE_W-1:0]   bt_rd_ff;

   // usage math
   logic [TIME_W-1:0]  st_val;
   logic [TIME_W-1:0]  elapsed_in;
   logic [TIME_W-1:0]  elapsed_ff;
   logic [USAGE_W-1:0] bt_hold_ff;
   logic [USAGE_W:0]   sum_wide;
   logic [USAGE_W-1:0] sum_sat;

   // first-fit search
   logic [NUM_CORES-1:0] elig;
   logic                 found;
   logic [CORE_W-1:0]    pick;
   logic                 grant;

   // result register
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 out_load;
   logic                 granted_ff;
   logic [CORE_W-1:0]    core_ff;
   logic [USAGE_W-1:0]   usage_ff;
   logic                 last_ff;

   // csr
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      if (csr_paddr[2] == CSR_WORD_CORES_IN_USE) begin
         csr_prdata = CSR_DW'(cores_in_use_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cores_in_use_ff <= CORES_IN_USE_RST;
      end else if (csr_wr && csr_paddr[2] == CSR_WORD_CORES_IN_USE) begin
         cores_in_use_ff <= csr_pwdata[CNT_W-1:0];
      end
   end

   // capture of the request
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         idx_ff  <= req_core_index;
         now_ff  <= req_now;
         zero_ff <= (req_count == '0);
      end
   end

   always_comb begin
      slots_in = slots_ff;
      if (cmd.load) begin
         if (req_count == '0) begin
            slots_in = CNT_W'(1);
         end else if (req_count > CNT_W'(MAX_SLOTS)) begin
            slots_in = CNT_W'(MAX_SLOTS);
         end else begin
            slots_in = req_count;
         end
      end else if (cmd.alloc_step) begin
         slots_in = slots_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= '0;
      end else begin
         slots_ff <= slots_in;
      end
   end

   // lowest free core inside the pool limit
   always_comb begin
      found = 1'b0;
      pick  = '0;
      for (int k = 0; k < NUM_CORES; k++) begin
         elig[k] = free_ff[k] && (k < int'(cores_in_use_ff));
      end
      for (int k = NUM_CORES - 1; k >= 0; k--) begin
         if (elig[k]) begin
            found = 1'b1;
            pick  = CORE_W'(k);
         end
      end
   end

   assign grant = cmd.alloc_step && found && !zero_ff;

   // usage math
   assign st_val = st_vld_ff[idx_ff] ? st_rd_ff : '0;

   always_comb begin
      if (mode_ff == MODE_READ && free_ff[idx_ff]) begin
         elapsed_in = '0;
      end else if (now_ff >= st_val) begin
         elapsed_in = now_ff - st_val;
      end else begin
         elapsed_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         elapsed_ff <= elapsed_in;
         bt_hold_ff <= bt_vld_ff[idx_ff] ? bt_rd_ff : '0;
      end
   end

   assign sum_wide = {1'b0, bt_hold_ff} + (USAGE_W + 1)'(elapsed_ff);
   assign sum_sat  = sum_wide[USAGE_W] ? USAGE_MAX : sum_wide[USAGE_W-1:0];

   // core state update
   always_comb begin
      free_in   = free_ff;
      st_vld_in = st_vld_ff;
      bt_vld_in = bt_vld_ff;
      if (grant) begin
         free_in[pick]   = 1'b0;
         st_vld_in[pick] = 1'b1;
      end
      if (cmd.accum_step && mode_ff == MODE_RELEASE) begin
         free_in[idx_ff]   = 1'b1;
         bt_vld_in[idx_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff   <= '1;
         st_vld_ff <= '0;
         bt_vld_ff <= '0;
      end else begin
         free_ff   <= free_in;
         st_vld_ff <= st_vld_in;
         bt_vld_ff <= bt_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (grant) begin
         start_time_ff[pick] <= now_ff;
      end
      if (cmd.accum_step && mode_ff == MODE_RELEASE) begin
         busy_total_ff[idx_ff] <= sum_sat;
      end
      if (cmd.mem_rd) begin
         st_rd_ff <= start_time_ff[idx_ff];
         bt_rd_ff <= busy_total_ff[idx_ff];
      end
   end

   // result register
   assign out_load = cmd.alloc_step || cmd.accum_step || cmd.single_step;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.alloc_step) begin
         granted_ff <= grant;
         core_ff    <= grant ? pick : '0;
         usage_ff   <= '0;
         last_ff    <= (slots_ff == CNT_W'(1));
      end else if (cmd.accum_step) begin
         granted_ff <= 1'b1;
         core_ff    <= idx_ff;
         usage_ff   <= sum_sat;
         last_ff    <= 1'b1;
      end else if (cmd.single_step) begin
         granted_ff <= 1'b0;
         core_ff    <= (mode_ff == MODE_RELEASE || mode_ff == MODE_READ) ? idx_ff : '0;
         usage_ff   <= '0;
         last_ff    <= 1'b1;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted      = granted_ff;
   assign rsp_granted_core = core_ff;
   assign rsp_usage        = usage_ff;
   assign rsp_last         = last_ff;

   // status
   assign sts.mode      = mode_ff;
   assign sts.idx_ok    = ({1'b0, idx_ff} < (CORE_W + 1)'(NUM_CORES));
   assign sts.last_slot = (slots_ff == CNT_W'(1));
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

endmodule

// ===== sv/core_pool_allocator_with_usage.sv =====
// top level of the core pool allocator with per-core busy time
//
//  port group | direction | transaction
//  req_*      | in        | one request: allocate, release or read
//  rsp_*      | out       | one result per requested slot, or one result
//  csr_*      | in/out    | cores_in_use at byte address 0
//
// allocate: dispatch, then one result per cycle per slot (up to 16) unless stalled
// release and read: dispatch, then the store read, elapsed and saturating add steps
// one request is in work at a time; a new one is taken while the last result waits
// a stalled rsp_ready holds the result register and pauses the sequence
// synchronous reset frees all cores and clears all times and totals at once
module core_pool_allocator_with_usage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_mode,
   input  logic [cpa_pkg::CNT_W-1:0]     req_count,
   input  logic [cpa_pkg::CORE_W-1:0]    req_core_index,
   input  logic [cpa_pkg::TIME_W-1:0]    req_now,
   input  logic                          req_list_end,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_granted,
   output logic [cpa_pkg::CORE_W-1:0]    rsp_granted_core,
   output logic [cpa_pkg::USAGE_W-1:0]   rsp_usage,
   output logic                          rsp_last,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [cpa_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [cpa_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [cpa_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);
   import cpa_pkg::*;

   cmd_type cmd;
   sts_type sts;

   cpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cpa_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_mode         (req_mode),
      .req_count        (req_count),
      .req_core_index   (req_core_index),
      .req_now          (req_now),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_granted      (rsp_granted),
      .rsp_granted_core (rsp_granted_core),
      .rsp_usage        (rsp_usage),
      .rsp_last         (rsp_last),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

endmodule

// ===== sv/cpa_checker.sv =====
// port-level checks of the core pool allocator and their binding
module cpa_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_granted,
   input logic [cpa_pkg::CORE_W-1:0]    rsp_granted_core,
   input logic [cpa_pkg::USAGE_W-1:0]   rsp_usage,
   input logic                          rsp_last,
   input logic                          csr_pready
);

   // result held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_granted)
         && $stable(rsp_granted_core) && $stable(rsp_usage) && $stable(rsp_last))
      else $error("result changed while stalled");

   // a not granted result carries no usage
   a_no_grant_usage: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_granted |-> rsp_usage == '0)
      else $error("usage on a result that is not granted");

   // one request in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("csr wait state");

endmodule

bind core_pool_allocator_with_usage cpa_checker u_cpa_checker (.*);

// ===== dv/pool_usage_scoreboard.sv =====
// transaction types and busy-time scoreboard for the core pool allocator bench
package pool_usage_tb_pkg;
   import cpa_pkg::*;

   localparam logic [1:0]        MODE_UNUSED           = 2'd3;
   localparam logic [CSR_AW-1:0] CSR_ADDR_CORES_IN_USE = '0;

   typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_LONG} rx_stall_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [CNT_W-1:0]  count;
      logic [CORE_W-1:0] core_index;
      logic [TIME_W-1:0] now;
      logic              list_end;
   } pool_req_type;

   typedef struct packed {
      logic               granted;
      logic [CORE_W-1:0]  granted_core;
      logic [USAGE_W-1:0] usage;
      logic               last;
   } pool_rsp_type;

   class usage_scoreboard;
      logic [CNT_W-1:0]   cores_in_use;
      bit                 core_free [NUM_CORES];
      logic [TIME_W-1:0]  start_time [NUM_CORES];
      logic [USAGE_W-1:0] busy_total [NUM_CORES];
      pool_rsp_type       expected_q [$];
      int                 errors;
      int                 checked;
      int                 grants;
      int                 unfilled;
      int                 saturated;
      int                 mode_seen [4];

      function void reset_state();
         for (int c = 0; c < NUM_CORES; c++) begin
            core_free[c]  = 1'b1;
            start_time[c] = '0;
            busy_total[c] = '0;
         end
         cores_in_use = CORES_IN_USE_RST;
         expected_q.delete();
      endfunction

      function void set_cores_in_use(logic [CNT_W-1:0] value);
         cores_in_use = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function logic [USAGE_W-1:0] sat_add(logic [USAGE_W-1:0] a, logic [USAGE_W-1:0] b);
         logic [USAGE_W:0] sum;
         sum = {1'b0, a} + {1'b0, b};
         return (sum > {1'b0, USAGE_MAX}) ? USAGE_MAX : sum[USAGE_W-1:0];
      endfunction

      // time running backward counts as no elapsed time
      function logic [USAGE_W-1:0] elapsed_secs(logic [TIME_W-1:0] now,
                                                logic [TIME_W-1:0] since);
         return (now >= since) ? USAGE_W'(now - since) : '0;
      endfunction

      function void push_result(bit granted, logic [CORE_W-1:0] core,
                                logic [USAGE_W-1:0] usage, bit last);
         pool_rsp_type r;
         r.granted      = granted;
         r.granted_core = core;
         r.usage        = usage;
         r.last         = last;
         if (usage == USAGE_MAX) saturated++;
         expected_q.push_back(r);
      endfunction

      function void note_request(pool_req_type req);
         int unsigned        limit;
         int unsigned        slots;
         int unsigned        scan;
         bit                 found;
         logic [USAGE_W-1:0] use_now;
         mode_seen[req.mode]++;
         case (req.mode)
            MODE_ALLOC: begin
               limit = (cores_in_use < NUM_CORES) ? cores_in_use : NUM_CORES;
               slots = (req.count > MAX_SLOTS) ? MAX_SLOTS : req.count;
               scan  = 0;
               if (slots == 0) begin
                  push_result(1'b0, '0, '0, 1'b1);
                  unfilled++;
               end
               for (int k = 0; k < slots; k++) begin
                  found = 1'b0;
                  while (scan < limit && !found) begin
                     if (core_free[scan]) begin
                        core_free[scan]  = 1'b0;
                        start_time[scan] = req.now;
                        push_result(1'b1, CORE_W'(scan), '0, k == slots - 1);
                        grants++;
                        found = 1'b1;
                     end
                     scan++;
                  end
                  if (!found) begin
                     push_result(1'b0, '0, '0, k == slots - 1);
                     unfilled++;
                  end
               end
            end
            MODE_RELEASE: begin
               core_free[req.core_index]  = 1'b1;
               busy_total[req.core_index] = sat_add(busy_total[req.core_index],
                  elapsed_secs(req.now, start_time[req.core_index]));
               push_result(1'b1, req.core_index, busy_total[req.core_index], 1'b1);
            end
            MODE_READ: begin
               use_now = busy_total[req.core_index];
               if (!core_free[req.core_index])
                  use_now = sat_add(use_now, elapsed_secs(req.now, start_time[req.core_index]));
               push_result(1'b1, req.core_index, use_now, 1'b1);
            end
            default: push_result(1'b0, '0, '0, 1'b1);
         endcase
      endfunction

      function void check_field(string name, logic [USAGE_W-1:0] exp_val,
                                logic [USAGE_W-1:0] act_val);
         if (act_val !== exp_val) begin
            errors++;
            $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, exp_val,
                     act_val);
         end
      endfunction

      function void check_result(pool_rsp_type got);
         pool_rsp_type exp_rsp;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t unexpected result: granted %0b core %0d usage %0h last %0b",
                     $time, got.granted, got.granted_core, got.usage, got.last);
            return;
         end
         exp_rsp = expected_q.pop_front();
         check_field("granted", exp_rsp.granted, got.granted);
         check_field("granted_core", exp_rsp.granted_core, got.granted_core);
         check_field("usage", exp_rsp.usage, got.usage);
         check_field("last", exp_rsp.last, got.last);
         checked++;
      endfunction
   endclass

endpackage

// ===== dv/tb_top.sv =====
// testbench top for the core pool allocator: stimulus, handshakes and final verdict
module tb_top;
   import cpa_pkg::*;
   import pool_usage_tb_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 20;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_mode = '0;
   logic [CNT_W-1:0]    req_count = '0;
   logic [CORE_W-1:0]   req_core_index = '0;
   logic [TIME_W-1:0]   req_now = '0;
   logic                req_list_end = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b1;
   logic                rsp_granted;
   logic [CORE_W-1:0]   rsp_granted_core;
   logic [USAGE_W-1:0]  rsp_usage;
   logic                rsp_last;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [CSR_DW-1:0]   csr_pwdata = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   usage_scoreboard     sb = new();
   rx_stall_type        rx_style = RX_ALWAYS;
   logic [7:0]          rx_pattern = 8'b1101_0110;
   int                  rx_hold = 0;
   int                  cycles = 0;
   int                  issued = 0;
   int                  burst_left = 0;
   bit                  sender_steady = 1'b0;
   logic [TIME_W-1:0]   sim_seconds = '0;

   core_pool_allocator_with_usage uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_count        (req_count),
      .req_core_index   (req_core_index),
      .req_now          (req_now),
      .req_list_end     (req_list_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_granted      (rsp_granted),
      .rsp_granted_core (rsp_granted_core),
      .rsp_usage        (rsp_usage),
      .rsp_last         (rsp_last),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin : watchdog
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin : rsp_stall_gen
      case (rx_style)
         RX_ALWAYS: rsp_ready <= 1'b1;
         RX_RANDOM: rsp_ready <= ($urandom_range(0, 3) != 0);
         RX_PATTERN: begin
            rx_pattern <= {rx_pattern[6:0], rx_pattern[7]};
            rsp_ready  <= rx_pattern[7];
         end
         default: begin
            if (rx_hold == 0) begin
               rx_hold   <= $urandom_range(0, 12);
               rsp_ready <= ~rsp_ready;
            end else begin
               rx_hold <= rx_hold - 1;
            end
         end
      endcase
   end

   always @(posedge clock) begin : rsp_monitor
      pool_rsp_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.granted      = rsp_granted;
         got.granted_core = rsp_granted_core;
         got.usage        = rsp_usage;
         got.last         = rsp_last;
         sb.check_result(got);
      end
   end

   // mostly forward steps, sometimes big jumps or an arbitrary (possibly earlier) time
   function automatic logic [TIME_W-1:0] next_now();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 5)
         sim_seconds = $urandom;
      else if (roll < 10)
         sim_seconds = sim_seconds + $urandom_range(100000, 32'h7FFF_FFFF);
      else
         sim_seconds = sim_seconds + $urandom_range(0, 500);
      return sim_seconds;
   endfunction

   task automatic issue(input logic [1:0] mode, input logic [CNT_W-1:0] count,
                        input logic [CORE_W-1:0] core, input logic [TIME_W-1:0] now,
                        input logic list_end);
      int           gap;
      pool_req_type item;
      item.mode       = mode;
      item.count      = count;
      item.core_index = core;
      item.now        = now;
      item.list_end   = list_end;
      if (issued % 50 == 0) begin
         rx_style      = rx_stall_type'($urandom_range(0, 3));
         sender_steady = ($urandom_range(0, 3) == 0);
      end
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap        = sender_steady ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_count      <= count;
      req_core_index <= core;
      req_now        <= now;
      req_list_end   <= list_end;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(item);
      issued++;
   endtask

   task automatic wait_pool_quiet();
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_cores_in_use(input logic [CNT_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_CORES_IN_USE;
      csr_pwdata  <= CSR_DW'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.set_cores_in_use(value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic release_busy_list(input int max_len);
      logic [CORE_W-1:0] busy_q [$];
      int                n;
      int                j;
      for (int c = 0; c < NUM_CORES; c++)
         if (!sb.core_free[c]) busy_q.push_back(CORE_W'(c));
      if (busy_q.size() == 0) return;
      n = $urandom_range(1, (busy_q.size() < max_len) ? busy_q.size() : max_len);
      for (int k = 0; k < n; k++) begin
         j = $urandom_range(0, busy_q.size() - 1);
         issue(MODE_RELEASE, CNT_W'($urandom), busy_q[j], next_now(), k == n - 1);
         busy_q.delete(j);
      end
   endtask

   task automatic alloc_release_sequence();
      int               roll;
      logic [CNT_W-1:0] count;
      roll = $urandom_range(0, 99);
      if (roll < 8)       count = '0;
      else if (roll < 70) count = CNT_W'($urandom_range(1, 4));
      else if (roll < 92) count = CNT_W'($urandom_range(5, 16));
      else                count = CNT_W'($urandom_range(17, 31));
      issue(MODE_ALLOC, count, CORE_W'($urandom), next_now(), 1'($urandom));
      repeat ($urandom_range(0, 2))
         issue(MODE_READ, CNT_W'($urandom), CORE_W'($urandom), next_now(), 1'($urandom));
      release_busy_list(4);
   endtask

   task automatic run_session(input int n_items);
      int target;
      target = issued + n_items;
      while (issued < target) begin
         if ($urandom_range(0, 99) < 15)
            issue(2'($urandom), CNT_W'($urandom), CORE_W'($urandom),
                  $urandom_range(0, 1) ? $urandom : next_now(), 1'($urandom));
         else
            alloc_release_sequence();
      end
   endtask

   task automatic run_directed();
      issue(MODE_READ, 5'd0, 4'd0, 32'd0, 1'b0);
      issue(MODE_ALLOC, 5'd0, 4'd9, 32'd10, 1'b0);
      issue(MODE_ALLOC, 5'd3, 4'd0, 32'd100, 1'b0);
      issue(MODE_READ, 5'd0, 4'd2, 32'd40, 1'b0);
      issue(MODE_RELEASE, 5'd0, 4'd1, 32'd150, 1'b0);
      issue(MODE_ALLOC, 5'd31, 4'hF, 32'd200, 1'b1);
      issue(MODE_RELEASE, 5'h1F, 4'd0, 32'd50, 1'b0);
      issue(MODE_RELEASE, 5'd0, 4'd1, 32'd1000, 1'b0);
      issue(MODE_READ, 5'd0, 4'd2, 32'd500, 1'b1);
      issue(MODE_RELEASE, 5'd0, 4'hF, 32'hFFFF_FFFF, 1'b0);
      issue(MODE_UNUSED, 5'h1F, 4'hF, 32'hFFFF_FFFF, 1'b1);
      issue(MODE_UNUSED, 5'd0, 4'd0, 32'd0, 1'b0);
      for (int c = 3; c <= 6; c++)
         issue(MODE_RELEASE, 5'd0, CORE_W'(c), 32'd2000, c == 6);
      issue(MODE_ALLOC, 5'd16, 4'd0, 32'hFFFF_FFFF, 1'b0);
      issue(MODE_READ, 5'd0, 4'hF, 32'd0, 1'b0);
      issue(MODE_ALLOC, 5'd1, 4'd0, 32'd3000, 1'b1);
      sim_seconds = 32'd4000;
   endtask

   // drive one core's total into saturation with long releases, other reads and releases mixed in
   task automatic run_saturation();
      logic [CORE_W-1:0] target;
      int                hammered;
      for (int c = 0; c < NUM_CORES; c++)
         issue(MODE_RELEASE, 5'd0, CORE_W'(c), 32'd0, c == NUM_CORES - 1);
      issue(MODE_ALLOC, 5'd16, 4'd0, 32'd0, 1'b0);
      target   = CORE_W'($urandom);
      hammered = 0;
      while (hammered < 260) begin
         if ($urandom_range(0, 19) == 0) begin
            if ($urandom_range(0, 1))
               issue(MODE_READ, CNT_W'($urandom), target, $urandom, 1'($urandom));
            else
               issue(MODE_RELEASE, CNT_W'($urandom),
                     target + CORE_W'($urandom_range(1, 15)), $urandom, 1'($urandom));
         end else begin
            issue(MODE_RELEASE, CNT_W'($urandom), target,
                  $urandom_range(32'hFFFF_FFFF, 32'hFFFF_0000), 1'($urandom));
            hammered++;
         end
      end
      issue(MODE_ALLOC, 5'd16, 4'd0, 32'd0, 1'b0);
      issue(MODE_READ, 5'd0, target, 32'hFFFF_FFFF, 1'b0);
      issue(MODE_READ, 5'd0, target, 32'd0, 1'b1);
   endtask

   initial begin
      logic [CNT_W-1:0] pool_sizes [5];
      pool_sizes = '{5'd1, 5'd0, 5'd31, 5'd16, 5'd16};
      pool_sizes[3] = CNT_W'($urandom_range(2, 15));
      sb.reset_state();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      foreach (pool_sizes[p]) begin
         wait_pool_quiet();
         write_cores_in_use(pool_sizes[p]);
         run_session(10);
      end
      wait_pool_quiet();
      write_cores_in_use(5'd16);
      run_saturation();
      wait_pool_quiet();
      $display("covered %0d allocate, %0d release, %0d read, %0d unused-mode transactions",
               sb.mode_seen[MODE_ALLOC], sb.mode_seen[MODE_RELEASE],
               sb.mode_seen[MODE_READ], sb.mode_seen[MODE_UNUSED]);
      $display("pools 0/1/16/31/mid: %0d grants, %0d unfilled, %0d saturated, %0d checked",
               sb.grants, sb.unfilled, sb.saturated, sb.checked);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
